// ===== design/kvtu_pkg.sv =====
package kvtu_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] data;
    logic        full_reject;
    logic [6:0]  entry_count;
  } rsp_t;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_SET    = 1'b1;

endpackage

// ===== design/kvtu_ram.sv =====
module kvtu_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/key_value_table_upsert.sv =====
// Associative key/value table with CAPACITY entries filled in arrival order.
// A request is taken when start is high and busy is low; func selects lookup
// or set. The table scans the filled entries through one read port of the key
// and value memories, one entry per cycle, lowest index first, and stops at
// the first match, or after the last filled entry on a miss. On an empty
// table a request is decided when it is accepted, without a scan. The
// result appears on rsp for exactly one cycle with done high and cannot be
// held off; the next request may be given in that same cycle. A set of a
// new key on a full table is dropped and flagged by full_reject.
module key_value_table_upsert import kvtu_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                state;
  logic                  op;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [IW-1:0]         scan_idx;
  logic [CW-1:0]         count;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  logic                  accept;
  logic                  op_sel;
  logic [KEY_BITS-1:0]   key_sel;
  logic [VALUE_BITS-1:0] value_sel;
  logic                  match;
  logic                  last;
  logic                  decide;
  logic                  room;
  logic                  append;
  logic                  reject;
  logic                  val_we;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  logic [CW-1:0]         count_next;
  logic [VALUE_BITS-1:0] data_next;

  always_comb begin
    accept     = start && (state == IDLE);
    op_sel     = (state == IDLE) ? req.func : op;
    key_sel    = (state == IDLE) ? KEY_BITS'(req.key) : key_q;
    value_sel  = (state == IDLE) ? VALUE_BITS'(req.value) : value_q;
    match      = (state == SCAN) && (rd_key == key_q);
    last       = (state == SCAN) && ((CW'(scan_idx) + CW'(1)) == count);
    decide     = (accept && (count == '0)) || match || last;
    room       = count < CW'(CAPACITY);
    append     = decide && !match && (op_sel == FUNC_SET) && room;
    reject     = decide && !match && (op_sel == FUNC_SET) && !room;
    val_we     = append || (match && (op == FUNC_SET));
    waddr      = match ? scan_idx : IW'(count);
    raddr      = (state == IDLE) ? '0 : scan_idx + IW'(1);
    count_next = append ? count + CW'(1) : count;
    if (!match) begin
      data_next = '0;
    end else if (op == FUNC_SET) begin
      data_next = value_q;
    end else begin
      data_next = rd_value;
    end
  end

  assign busy = (state != IDLE);

  kvtu_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (append),
    .waddr (waddr),
    .wdata (key_sel),
    .raddr (raddr),
    .rdata (rd_key)
  );

  kvtu_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (value_sel),
    .raddr (raddr),
    .rdata (rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done  <= decide;
      count <= count_next;
      if (decide) begin
        rsp.hit         <= match;
        rsp.data        <= 32'(data_next);
        rsp.full_reject <= reject;
        rsp.entry_count <= 7'(count_next);
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            op       <= req.func;
            key_q    <= KEY_BITS'(req.key);
            value_q  <= VALUE_BITS'(req.value);
            scan_idx <= '0;
            if (count != '0) begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (decide) begin
            state <= IDLE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/kvtu_chk.sv =====
module kvtu_chk import kvtu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t req,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither scanning nor answered");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still scanning");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a request in flight");

  a_miss_data_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.hit) |-> (rsp.data == 32'd0))
    else $error("miss returned nonzero data");

  a_reject_is_miss: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.full_reject) |-> !rsp.hit)
    else $error("reject flagged on a hit");

endmodule

bind key_value_table_upsert kvtu_chk u_kvtu_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// ===== verif/tb_top.sv =====
module tb_top;
  import kvtu_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int ITEMS       = 1050;

  class table_tracker;
    logic [31:0] stored_keys[TABLE_DEPTH];
    logic [31:0] stored_values[TABLE_DEPTH];
    int          fill;
    rsp_t        pending_rsp[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   idx;
      e   = '0;
      idx = -1;
      for (int i = 0; i < fill; i++) begin
        if (idx < 0 && stored_keys[i] == r.key) idx = i;
      end
      if (r.func == FUNC_SET) begin
        if (idx >= 0) begin
          stored_values[idx] = r.value;
        end else if (fill < TABLE_DEPTH) begin
          stored_keys[fill]   = r.key;
          stored_values[fill] = r.value;
          fill++;
        end else begin
          e.full_reject = 1'b1;
        end
      end
      if (idx >= 0) begin
        e.hit  = 1'b1;
        e.data = stored_values[idx];
      end
      e.entry_count = 7'(fill);
      pending_rsp.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response hit=%0d data=%h full_reject=%0d entry_count=%0d",
                 $time, got.hit, got.data, got.full_reject, got.entry_count);
        return;
      end
      e = pending_rsp.pop_front();
      if (got.hit !== e.hit) begin
        errors++;
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, got.hit);
      end
      if (got.data !== e.data) begin
        errors++;
        $display("%0t: data expected %h actual %h", $time, e.data, got.data);
      end
      if (got.full_reject !== e.full_reject) begin
        errors++;
        $display("%0t: full_reject expected %0d actual %0d", $time, e.full_reject,
                 got.full_reject);
      end
      if (got.entry_count !== e.entry_count) begin
        errors++;
        $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                 got.entry_count);
      end
    endfunction

    function int pending();
      return pending_rsp.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  table_tracker tracker;

  key_value_table_upsert u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_response(rsp);
      if (start && !busy) tracker.note_request(req);
    end
  end

  task automatic send(input req_t r);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_fields(input logic f, input logic [31:0] k, input logic [31:0] v);
    req_t r;
    r.func  = f;
    r.key   = k;
    r.value = v;
    send(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic req_t pick_request();
    req_t        r;
    int          roll;
    logic [31:0] known;
    roll    = $urandom_range(0, 99);
    r.func  = ($urandom_range(0, 1) == 1) ? FUNC_SET : FUNC_LOOKUP;
    known   = (tracker.fill > 0) ?
              tracker.stored_keys[$urandom_range(0, tracker.fill - 1)] : $urandom();
    if (roll < 60) r.key = known;
    else if (roll < 70) r.key = known ^ (32'h1 << $urandom_range(0, 31));
    else r.key = $urandom();
    case ($urandom_range(0, 9))
      0: r.value = 32'h0000_0000;
      1: r.value = 32'hFFFF_FFFF;
      default: r.value = $urandom();
    endcase
    return r;
  endfunction

  initial begin
    int sent;
    int burst;
    int gap;
    clk     = 1'b0;
    rst     = 1'b1;
    start   = 1'b0;
    req     = '0;
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_fields(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_fields(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(FUNC_SET,    32'h0000_0000, 32'hFFFF_FFFF);
    send_fields(FUNC_SET,    32'hFFFF_FFFF, 32'h0000_0000);
    send_fields(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_fields(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_fields(FUNC_SET,    32'h0000_0000, 32'h1234_5678);
    send_fields(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_fields(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_0000);
    send_fields(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_fields(FUNC_SET,    32'h8000_0000, 32'hAAAA_AAAA);
    send_fields(FUNC_SET,    32'h7FFF_FFFF, 32'h5555_5555);
    send_fields(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
    send_fields(FUNC_SET,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_fields(FUNC_LOOKUP, 32'h8000_0000, 32'h5555_5555);
    send_fields(FUNC_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sent = 16;

    while (sent < ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < ITEMS; b++) begin
        send(pick_request());
        sent++;
        if (sent == ITEMS / 2) drain();
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    drain();
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS key_value_table_upsert");
    end else begin
      $display("FAIL key_value_table_upsert");
    end
    $finish;
  end

  initial begin
    #(8 * 1000000);
    $display("FAIL key_value_table_upsert");
    $finish;
  end

endmodule
